// ===== rtl/fmul25519_pkg.sv =====
// Shared constants for the GF(2^255-19) radix-2^51 field multiplier.
// Used by field_mul_mod_p25519_core; depends on nothing.
package fmul25519_pkg;

  localparam int IN_W    = 55;   // input limb width, signed
  localparam int LIMB_W  = 51;   // radix of the limb representation
  localparam int OUT4_W  = 52;   // signed width of result limb 4
  localparam int NLIMB   = 5;

  // Each 55-bit operand limb is split into a 28-bit unsigned low part and a
  // 27-bit signed high part, so every multiplier is at most 29 x 29 bits.
  localparam int SPLIT   = 28;
  localparam int HI_W    = IN_W - SPLIT;
  localparam int PP_W    = 2 * (SPLIT + 1);
  localparam int PROD_W  = 2 * IN_W;

  // Largest column sum is 77 * 2^108, so 118 bits leave ample headroom.
  localparam int ACC_W   = 118;

  localparam int FOLD    = 19;
  localparam logic [ACC_W-1:0] HALF_RADIX = ACC_W'(1) << (LIMB_W - 1);

  // Register stages from an accepted beat to its result strobe.
  localparam int LATENCY = 10;

  // Worst-case magnitude of result limb 4.
  localparam logic signed [OUT4_W-1:0] OUT4_MAX =
    OUT4_W'((64'sd1 <<< (LIMB_W - 1)) + (64'sd1 <<< 14));

endpackage

// ===== rtl/field_mul_mod_p25519_core.sv =====
// Pipelined GF(2^255-19) multiplier on five signed radix-2^51 limbs.
// Depends on fmul25519_pkg for widths, the rounding constant, the limb 4 bound and the latency.

// A beat is taken on every clock edge at which start is high; busy is always
// low, so a new operand pair may enter every cycle. Each result appears on
// out_limb0..out_limb4 for exactly one cycle with done high, in the order
// the operands came in. The core is a ten-stage pipeline: one stage of 100
// partial multipliers of at most 29 x 29 bits, one to assemble the 25 limb
// products, one to form the column sums, one for the fold by 19, and six for
// the carry chain, one dependent carry per stage. The result cannot be held
// off; a receiver must take it in the cycle it is shown.
module field_mul_mod_p25519_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  a_limb0,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  a_limb1,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  a_limb2,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  a_limb3,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  a_limb4,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  b_limb0,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  b_limb1,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  b_limb2,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  b_limb3,
  input  logic signed [fmul25519_pkg::IN_W-1:0]  b_limb4,
  output logic                                   done,
  output logic        [fmul25519_pkg::LIMB_W-1:0] out_limb0,
  output logic        [fmul25519_pkg::LIMB_W-1:0] out_limb1,
  output logic        [fmul25519_pkg::LIMB_W-1:0] out_limb2,
  output logic        [fmul25519_pkg::LIMB_W-1:0] out_limb3,
  output logic signed [fmul25519_pkg::OUT4_W-1:0] out_limb4
);

  localparam int IN_W    = fmul25519_pkg::IN_W;
  localparam int LIMB_W  = fmul25519_pkg::LIMB_W;
  localparam int OUT4_W  = fmul25519_pkg::OUT4_W;
  localparam int NLIMB   = fmul25519_pkg::NLIMB;
  localparam int SPLIT   = fmul25519_pkg::SPLIT;
  localparam int PP_W    = fmul25519_pkg::PP_W;
  localparam int PROD_W  = fmul25519_pkg::PROD_W;
  localparam int ACC_W   = fmul25519_pkg::ACC_W;
  localparam int LATENCY = fmul25519_pkg::LATENCY;

  logic signed [IN_W-1:0] a_in [NLIMB];
  logic signed [IN_W-1:0] b_in [NLIMB];

  assign a_in[0] = a_limb0;
  assign a_in[1] = a_limb1;
  assign a_in[2] = a_limb2;
  assign a_in[3] = a_limb3;
  assign a_in[4] = a_limb4;
  assign b_in[0] = b_limb0;
  assign b_in[1] = b_limb1;
  assign b_in[2] = b_limb2;
  assign b_in[3] = b_limb3;
  assign b_in[4] = b_limb4;

  assign busy = 1'b0;

  // Valid bits travel alongside the data stages.
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end

  assign done = vld[LATENCY-1];

  // Stage 1: four partial products for each of the 25 limb pairs.
  logic signed [PP_W-1:0] pp_ll [NLIMB][NLIMB];
  logic signed [PP_W-1:0] pp_lh [NLIMB][NLIMB];
  logic signed [PP_W-1:0] pp_hl [NLIMB][NLIMB];
  logic signed [PP_W-1:0] pp_hh [NLIMB][NLIMB];

  always_ff @(posedge clk) begin
    for (int j = 0; j < NLIMB; j++) begin
      for (int k = 0; k < NLIMB; k++) begin
        pp_ll[j][k] <= $signed({1'b0, a_in[j][SPLIT-1:0]})
                     * $signed({1'b0, b_in[k][SPLIT-1:0]});
        pp_lh[j][k] <= $signed({1'b0, a_in[j][SPLIT-1:0]})
                     * $signed(b_in[k][IN_W-1:SPLIT]);
        pp_hl[j][k] <= $signed(a_in[j][IN_W-1:SPLIT])
                     * $signed({1'b0, b_in[k][SPLIT-1:0]});
        pp_hh[j][k] <= $signed(a_in[j][IN_W-1:SPLIT])
                     * $signed(b_in[k][IN_W-1:SPLIT]);
      end
    end
  end

  // Stage 2: assemble the exact 110-bit product a_j * b_k.
  logic signed [PROD_W-1:0] prod      [NLIMB][NLIMB];
  logic signed [PROD_W-1:0] prod_next [NLIMB][NLIMB];

  always_comb begin
    for (int j = 0; j < NLIMB; j++) begin
      for (int k = 0; k < NLIMB; k++) begin
        prod_next[j][k] = PROD_W'(pp_ll[j][k])
                        + ((PROD_W'(pp_lh[j][k]) + PROD_W'(pp_hl[j][k])) <<< SPLIT)
                        + (PROD_W'(pp_hh[j][k]) <<< (2 * SPLIT));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // Stage 3: column sums. Products of weight 2^255 and above go to the high
  // sum of the column five places down, to be folded with the factor 19.
  logic signed [ACC_W-1:0] col_lo      [NLIMB];
  logic signed [ACC_W-1:0] col_hi      [NLIMB];
  logic signed [ACC_W-1:0] col_lo_next [NLIMB];
  logic signed [ACC_W-1:0] col_hi_next [NLIMB];

  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      col_lo_next[i] = '0;
      col_hi_next[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        if (j <= i) begin
          col_lo_next[i] = col_lo_next[i] + ACC_W'(prod[j][i-j]);
        end else begin
          col_hi_next[i] = col_hi_next[i] + ACC_W'(prod[j][i-j+NLIMB]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    col_lo <= col_lo_next;
    col_hi <= col_hi_next;
  end

  // Stage 4: fold, r = lo + 19 * hi, with 19 as 16 + 2 + 1.
  logic signed [ACC_W-1:0] s4 [NLIMB];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLIMB; i++) begin
      s4[i] <= col_lo[i] + (col_hi[i] <<< 4) + (col_hi[i] <<< 1) + col_hi[i];
    end
  end

  // Stage 5: limb 3 carries into limb 4.
  logic signed [ACC_W-1:0] s5 [NLIMB];

  always_ff @(posedge clk) begin
    s5[0] <= s4[0];
    s5[1] <= s4[1];
    s5[2] <= s4[2];
    s5[3] <= ACC_W'(s4[3][LIMB_W-1:0]);
    s5[4] <= s4[4] + (s4[3] >>> LIMB_W);
  end

  // Stage 6: take the nearest multiple of 2^51 out of limb 4 and fold that
  // carry into limb 0 with the factor 19.
  logic signed [ACC_W-1:0] s6 [NLIMB];
  logic signed [ACC_W-1:0] top_carry;

  assign top_carry = (s5[4] + $signed(fmul25519_pkg::HALF_RADIX)) >>> LIMB_W;

  always_ff @(posedge clk) begin
    s6[0] <= s5[0] + (top_carry <<< 4) + (top_carry <<< 1) + top_carry;
    s6[1] <= s5[1];
    s6[2] <= s5[2];
    s6[3] <= s5[3];
    s6[4] <= s5[4] - (top_carry <<< LIMB_W);
  end

  // Stages 7 to 9: ripple the carries from limb 0 up to limb 3.
  logic signed [ACC_W-1:0] s7 [NLIMB];
  logic signed [ACC_W-1:0] s8 [NLIMB];
  logic signed [ACC_W-1:0] s9 [NLIMB];

  always_ff @(posedge clk) begin
    s7[0] <= s6[0];
    s7[1] <= s6[1] + (s6[0] >>> LIMB_W);
    s7[2] <= s6[2];
    s7[3] <= s6[3];
    s7[4] <= s6[4];
    s8[0] <= s7[0];
    s8[1] <= s7[1];
    s8[2] <= s7[2] + (s7[1] >>> LIMB_W);
    s8[3] <= s7[3];
    s8[4] <= s7[4];
    s9[0] <= s8[0];
    s9[1] <= s8[1];
    s9[2] <= s8[2];
    s9[3] <= s8[3] + (s8[2] >>> LIMB_W);
    s9[4] <= s8[4];
  end

  // Stage 10: limb 3's overflow into limb 4 and the output register.
  logic signed [ACC_W-1:0] limb4_sum;

  assign limb4_sum = s9[4] + (s9[3] >>> LIMB_W);

  always_ff @(posedge clk) begin
    out_limb0 <= s9[0][LIMB_W-1:0];
    out_limb1 <= s9[1][LIMB_W-1:0];
    out_limb2 <= s9[2][LIMB_W-1:0];
    out_limb3 <= s9[3][LIMB_W-1:0];
    out_limb4 <= limb4_sum[OUT4_W-1:0];
  end

  // Every accepted beat yields its result strobe at the end of the pipeline.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("accepted beat did not produce a result on time");

  // No result strobe without a matching accepted beat.
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result strobe without an accepted beat");

  // The partial reduction keeps limb 4 within about 2^50.
  a_limb4_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (out_limb4 <= fmul25519_pkg::OUT4_MAX)
          && (out_limb4 >= -fmul25519_pkg::OUT4_MAX))
    else $error("result limb 4 out of range after reduction");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for field_mul_mod_p25519_core, the GF(2^255-19) multiplier.
// It predicts every product independently and checks each done beat in order.
// Depends on fmul25519_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLIMB   = fmul25519_pkg::NLIMB;
  localparam int IN_W    = fmul25519_pkg::IN_W;
  localparam int LIMB_W  = fmul25519_pkg::LIMB_W;
  localparam int OUT4_W  = fmul25519_pkg::OUT4_W;
  localparam int FOLD    = fmul25519_pkg::FOLD;
  localparam int LATENCY = fmul25519_pkg::LATENCY;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_TAIL    = 200;

  typedef logic signed [127:0] wide_t;
  typedef logic [NLIMB-1:0][IN_W-1:0] limbs_t;

  typedef struct packed {
    limbs_t a;
    limbs_t b;
  } operand_t;

  typedef struct packed {
    logic [3:0][LIMB_W-1:0] low;
    logic [OUT4_W-1:0]      top;
  } product_t;

  localparam wide_t FOLD_W = wide_t'(FOLD);
  localparam wide_t HALF_W = wide_t'(1) <<< (LIMB_W - 1);
  localparam wide_t MASK_W = (wide_t'(1) <<< LIMB_W) - wide_t'(1);

  localparam logic [IN_W-1:0] LIMB_MAX     = {1'b0, {(IN_W - 1){1'b1}}};
  localparam logic [IN_W-1:0] LIMB_MIN     = {1'b1, {(IN_W - 1){1'b0}}};
  localparam logic [IN_W-1:0] LADDER_CONST = IN_W'(121666);
  localparam logic [IN_W-1:0] RADIX_MASK   = IN_W'((64'd1 << LIMB_W) - 64'd1);

  class product_scoreboard;
    product_t expected_products[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact product in 128-bit arithmetic, then the partial reduction of the block.
    function product_t reduce_product(operand_t op);
      wide_t    ai[NLIMB];
      wide_t    bi[NLIMB];
      wide_t    col[NLIMB];
      wide_t    low_sum;
      wide_t    high_sum;
      wide_t    carry;
      product_t res;
      for (int i = 0; i < NLIMB; i++) begin
        ai[i] = $signed(op.a[i]);
        bi[i] = $signed(op.b[i]);
      end
      for (int k = 0; k < NLIMB; k++) begin
        low_sum  = '0;
        high_sum = '0;
        for (int j = 0; j < NLIMB; j++) begin
          if (j <= k) begin
            low_sum += ai[j] * bi[k - j];
          end else begin
            high_sum += ai[j] * bi[k - j + NLIMB];
          end
        end
        col[k] = low_sum + FOLD_W * high_sum;
      end
      col[4] += col[3] >>> LIMB_W;
      col[3] &= MASK_W;
      carry   = (col[4] + HALF_W) >>> LIMB_W;
      col[0] += FOLD_W * carry;
      col[4] -= carry <<< LIMB_W;
      col[1] += col[0] >>> LIMB_W;
      col[2] += col[1] >>> LIMB_W;
      col[3] += col[2] >>> LIMB_W;
      col[4] += col[3] >>> LIMB_W;
      for (int i = 0; i < 4; i++) begin
        res.low[i] = col[i][LIMB_W-1:0];
      end
      res.top = col[4][OUT4_W-1:0];
      return res;
    endfunction

    function void note_operands(operand_t op);
      expected_products.push_back(reduce_product(op));
    endfunction

    function void check_product(product_t got);
      product_t want;
      bit       bad;
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected product beat: %h %h %h %h %h",
                   got.low[0], got.low[1], got.low[2], got.low[3], got.top);
        end
        return;
      end
      want = expected_products.pop_front();
      bad  = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (got.low[i] !== want.low[i]) bad = 1'b1;
      end
      if (got.top !== want.top) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("product mismatch: expected %h %h %h %h %h, got %h %h %h %h %h",
                   want.low[0], want.low[1], want.low[2], want.low[3], want.top,
                   got.low[0], got.low[1], got.low[2], got.low[3], got.top);
        end
      end
    endfunction

    function int pending();
      return expected_products.size();
    endfunction
  endclass

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic signed [IN_W-1:0] a_limb0 = '0, a_limb1 = '0, a_limb2 = '0, a_limb3 = '0, a_limb4 = '0;
  logic signed [IN_W-1:0] b_limb0 = '0, b_limb1 = '0, b_limb2 = '0, b_limb3 = '0, b_limb4 = '0;
  logic        [LIMB_W-1:0] out_limb0, out_limb1, out_limb2, out_limb3;
  logic signed [OUT4_W-1:0] out_limb4;

  int cycle_count = 0;
  product_scoreboard sb = new();

  field_mul_mod_p25519_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .a_limb0   (a_limb0),
    .a_limb1   (a_limb1),
    .a_limb2   (a_limb2),
    .a_limb3   (a_limb3),
    .a_limb4   (a_limb4),
    .b_limb0   (b_limb0),
    .b_limb1   (b_limb1),
    .b_limb2   (b_limb2),
    .b_limb3   (b_limb3),
    .b_limb4   (b_limb4),
    .done      (done),
    .out_limb0 (out_limb0),
    .out_limb1 (out_limb1),
    .out_limb2 (out_limb2),
    .out_limb3 (out_limb3),
    .out_limb4 (out_limb4)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    product_t got;
    if (!rst && done) begin
      got.low[0] = out_limb0;
      got.low[1] = out_limb1;
      got.low[2] = out_limb2;
      got.low[3] = out_limb3;
      got.top    = out_limb4;
      sb.check_product(got);
    end
  end

  function automatic limbs_t splat(logic [IN_W-1:0] v);
    limbs_t l;
    for (int i = 0; i < NLIMB; i++) l[i] = v;
    return l;
  endfunction

  function automatic limbs_t scalar(logic [IN_W-1:0] v);
    limbs_t l;
    l    = '0;
    l[0] = v;
    return l;
  endfunction

  function automatic logic [IN_W-1:0] random_limb();
    logic [63:0]     raw;
    logic [IN_W-1:0] v;
    longint          wide;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = raw[IN_W-1:0];
      4: begin
        case ($urandom_range(0, 3))
          0:       v = LIMB_MAX;
          1:       v = LIMB_MIN;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      5: v = raw[IN_W-1:0] & RADIX_MASK;
      6: v = IN_W'(int'($urandom_range(0, 255)) - 128);
      7: begin
        // Values just around the radix and its nearby powers of two.
        wide = (longint'(1) <<< $urandom_range(48, 54)) + longint'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) wide = -wide;
        v = wide[IN_W-1:0];
      end
      8: begin
        wide = -longint'(raw[LIMB_W-1:0]);
        v = wide[IN_W-1:0];
      end
      default: begin
        v = '0;
        v[$urandom_range(0, IN_W - 1)] = 1'b1;
      end
    endcase
    return v;
  endfunction

  function automatic operand_t random_operands();
    operand_t op;
    int       kind;
    for (int i = 0; i < NLIMB; i++) begin
      op.a[i] = random_limb();
      op.b[i] = random_limb();
    end
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      op.b = op.a;
    end else if (kind == 3) begin
      op.b = scalar(LADDER_CONST);
    end else if (kind == 4) begin
      op.b = scalar(IN_W'(1));
    end
    return op;
  endfunction

  task automatic drive_operands(operand_t op);
    a_limb0 <= op.a[0];
    a_limb1 <= op.a[1];
    a_limb2 <= op.a[2];
    a_limb3 <= op.a[3];
    a_limb4 <= op.a[4];
    b_limb0 <= op.b[0];
    b_limb1 <= op.b[1];
    b_limb2 <= op.b[2];
    b_limb3 <= op.b[3];
    b_limb4 <= op.b[4];
  endtask

  // Holds one operand beat until the core takes it; start stays high for a following beat.
  task automatic issue(operand_t op);
    drive_operands(op);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_operands(op);
  endtask

  // Idle cycles carry random garbage on the operand ports.
  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) begin
      drive_operands(random_operands());
      @(posedge clk);
    end
  endtask

  task automatic issue_pair(limbs_t a, limbs_t b);
    operand_t op;
    op.a = a;
    op.b = b;
    issue(op);
  endtask

  task automatic run_directed();
    operand_t r;
    limbs_t   p;
    r = random_operands();
    p = splat(RADIX_MASK);
    p[0] = RADIX_MASK - IN_W'(18);
    issue_pair(splat('0), splat('0));
    issue_pair(splat(LIMB_MAX), splat(LIMB_MAX));
    issue_pair(splat(LIMB_MIN), splat(LIMB_MIN));
    issue_pair(splat(LIMB_MAX), splat(LIMB_MIN));
    issue_pair(splat('1), splat('1));
    issue_pair(scalar(IN_W'(1)), r.b);
    issue_pair(r.a, r.a);
    issue_pair(splat(LIMB_MAX), splat(LIMB_MAX));
    issue_pair(r.a, scalar(LADDER_CONST));
    issue_pair(splat(LIMB_MAX), scalar(LADDER_CONST));
    issue_pair(splat(LIMB_MIN), scalar(LADDER_CONST));
    idle(3);
    issue_pair(p, scalar(IN_W'(1)));
    issue_pair(p, p);
    issue_pair(splat(RADIX_MASK), splat(RADIX_MASK));
    issue_pair({LIMB_MAX, LIMB_MIN, LIMB_MAX, LIMB_MIN, LIMB_MAX},
               {LIMB_MIN, LIMB_MAX, LIMB_MIN, LIMB_MAX, LIMB_MIN});
    // Terms that land only in the folded high columns.
    issue_pair({LIMB_MAX, 220'd0}, {LIMB_MAX, 220'd0});
    issue_pair({LIMB_MIN, 220'd0}, {LIMB_MIN, 220'd0});
    idle(1);
    // Limb 4 sitting on either side of the rounding point.
    issue_pair({IN_W'(64'd1 << (LIMB_W - 1)), 220'd0}, scalar(IN_W'(1)));
    issue_pair({IN_W'((64'd1 << (LIMB_W - 1)) - 64'd1), 220'd0}, scalar(IN_W'(1)));
    issue_pair({IN_W'(-(64'sd1 <<< (LIMB_W - 1))), 220'd0}, scalar(IN_W'(1)));
    issue_pair({IN_W'(-(64'sd1 <<< (LIMB_W - 1)) - 64'sd1), 220'd0}, scalar(IN_W'(1)));
    issue_pair(splat(LIMB_MAX), splat('1));
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    bit idle_on;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    idle_on = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i < RANDOM_ITEMS - CALM_TAIL && idle_on && $urandom_range(0, 3) == 0) begin
        idle($urandom_range(1, 12));
      end
      issue(random_operands());
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
